// ===== rtl/core/eos_pkg.sv =====
// ----------------------------------------------------------------------------
// eos_pkg
// Shared types and constants of the orbit step core: word formats, register
// codes and reset values, internal widths of the step datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package eos_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;
   localparam int STEP_BITS = 24;
   localparam int GM_BITS   = 31;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = GM_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEP_SIZE = 2'd0,
      CSR_GRAVITY   = 2'd1
   } csr_index_type;

   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(16777);
   localparam logic [GM_BITS-1:0]   GM_RESET   = GM_BITS'(662337929);

   // datapath widths
   localparam int HGM_BITS   = STEP_BITS + GM_BITS;
   localparam int SQ_BITS    = 2 * WORD_BITS;
   localparam int RAD_BITS   = WORD_BITS;
   localparam int NUM_BITS   = HGM_BITS + WORD_BITS + FRAC_BITS;
   localparam int DEN_BITS   = SQ_BITS + RAD_BITS;
   localparam int QUO_BITS   = WORD_BITS + 1;
   localparam int CMP_BITS   = DEN_BITS + QUO_BITS;
   localparam int TRIAL_BITS = SQ_BITS + 2;
   localparam int PRODV_BITS = WORD_BITS + STEP_BITS;
   localparam int INC_BITS   = PRODV_BITS + 1 - FRAC_BITS;
   localparam int EXT_BITS   = WORD_BITS + 3;
   localparam int NHI_BITS   = WORD_BITS + HGM_BITS - WORD_BITS;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [2:0][WORD_BITS-1:0] vec3_type;

   typedef struct packed {
      word_type pos_x;
      word_type pos_y;
      word_type pos_z;
      word_type vel_x;
      word_type vel_y;
      word_type vel_z;
   } eos_req_type;

   typedef struct packed {
      word_type next_pos_x;
      word_type next_pos_y;
      word_type next_pos_z;
      word_type next_vel_x;
      word_type next_vel_y;
      word_type next_vel_z;
      word_type radius;
      logic     saturated;
      logic     zero_radius;
   } eos_rsp_type;

   // state that rides along the long part of the pipeline
   typedef struct packed {
      logic [2:0]                p_neg;
      vec3_type                  vel;
      vec3_type                  npos;
      logic                      sat;
      logic [2:0][NUM_BITS-1:0]  num;
      logic [SQ_BITS-1:0]        r2;
      logic                      zero;
      logic [RAD_BITS-1:0]       root;
      logic [DEN_BITS-1:0]       den;
   } eos_carry_type;

   typedef struct packed {
      logic [2:0][NUM_BITS-1:0] rem;
      logic [2:0][QUO_BITS-1:0] quo;
      logic [2:0]               ovf;
   } eos_div_type;

endpackage

`default_nettype wire

// ===== rtl/core/eos_pipe.sv =====
// ----------------------------------------------------------------------------
// eos_pipe
// Step datapath: squares and position update, bit-per-stage square root,
// r^2*r product, bit-per-stage division of the velocity terms, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module eos_pipe import eos_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire eos_req_type          in_word,
   input  wire logic [STEP_BITS-1:0] step,
   input  wire logic [HGM_BITS-1:0]  hgm,
   output logic                      out_valid,
   output eos_rsp_type               out_word
);

   localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [QUO_BITS-1:0]  CAP   = QUO_BITS'(1) << WORD_BITS;

   function automatic word_type mag_of(input word_type v);
      return v[WORD_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   // {clipped, value}
   function automatic logic [WORD_BITS:0] clamp_ext(input logic [EXT_BITS-1:0] s);
      logic [EXT_BITS-WORD_BITS:0] top;
      top = s[EXT_BITS-1:WORD_BITS-1];
      if (&top || ~|top) return {1'b0, s[WORD_BITS-1:0]};
      else if (s[EXT_BITS-1]) return {1'b1, W_MIN};
      else return {1'b1, W_MAX};
   endfunction

   // stage 1: capture and magnitudes
   logic                s1_valid_ff;
   vec3_type            s1_pos_ff, s1_vel_ff, s1_pm_ff, s1_vm_ff;
   vec3_type            pos_in, vel_in;

   assign pos_in = {in_word.pos_z, in_word.pos_y, in_word.pos_x};
   assign vel_in = {in_word.vel_z, in_word.vel_y, in_word.vel_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pos_ff <= pos_in;
         s1_vel_ff <= vel_in;
         for (int i = 0; i < 3; i++) begin
            s1_pm_ff[i] <= mag_of(pos_in[i]);
            s1_vm_ff[i] <= mag_of(vel_in[i]);
         end
      end
   end

   // stage 2: squares and velocity times step
   logic                            s2_valid_ff;
   vec3_type                        s2_pos_ff, s2_vel_ff, s2_pm_ff;
   logic [2:0][SQ_BITS-1:0]         s2_sq_ff;
   logic [2:0][PRODV_BITS-1:0]      s2_dm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pos_ff <= s1_pos_ff;
         s2_vel_ff <= s1_vel_ff;
         s2_pm_ff  <= s1_pm_ff;
         for (int i = 0; i < 3; i++) begin
            s2_sq_ff[i] <= SQ_BITS'(s1_pm_ff[i]) * SQ_BITS'(s1_pm_ff[i]);
            s2_dm_ff[i] <= PRODV_BITS'(s1_vm_ff[i]) * PRODV_BITS'(step);
         end
      end
   end

   // stage 3: r^2, new position, numerator partial products
   logic                          s3_valid_ff;
   logic [SQ_BITS-1:0]            s3_r2_ff;
   vec3_type                      s3_vel_ff, s3_npos_ff;
   logic [2:0]                    s3_neg_ff;
   logic                          s3_sat_ff;
   logic [2:0][SQ_BITS-1:0]       s3_nlo_ff;
   logic [2:0][NHI_BITS-1:0]      s3_nhi_ff;
   vec3_type                      s3_npos_in;
   logic                          s3_sat_in;

   always_comb begin
      logic [PRODV_BITS:0]   rnd;
      logic [INC_BITS-1:0]   inc;
      logic [EXT_BITS-1:0]   pext, sum;
      logic [WORD_BITS:0]    cl;
      s3_sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         // round half away from zero on the magnitude
         rnd  = {1'b0, s2_dm_ff[i]} + ((PRODV_BITS+1)'(1) << (FRAC_BITS-1));
         inc  = rnd[PRODV_BITS:FRAC_BITS];
         pext = {{(EXT_BITS-WORD_BITS){s2_pos_ff[i][WORD_BITS-1]}}, s2_pos_ff[i]};
         sum  = s2_vel_ff[i][WORD_BITS-1] ? pext - EXT_BITS'(inc) : pext + EXT_BITS'(inc);
         cl   = clamp_ext(sum);
         s3_npos_in[i] = cl[WORD_BITS-1:0];
         s3_sat_in     = s3_sat_in | cl[WORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_r2_ff   <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
         s3_vel_ff  <= s2_vel_ff;
         s3_npos_ff <= s3_npos_in;
         s3_sat_ff  <= s3_sat_in;
         for (int i = 0; i < 3; i++) begin
            s3_neg_ff[i] <= s2_pos_ff[i][WORD_BITS-1];
            s3_nlo_ff[i] <= SQ_BITS'(s2_pm_ff[i]) * SQ_BITS'(hgm[WORD_BITS-1:0]);
            s3_nhi_ff[i] <= NHI_BITS'(s2_pm_ff[i]) * NHI_BITS'(hgm[HGM_BITS-1:WORD_BITS]);
         end
      end
   end

   // stage 4 and the square root stages
   logic                     sq_valid_ff [0:RAD_BITS];
   eos_carry_type            cr_ff       [0:RAD_BITS];
   logic [SQ_BITS-1:0]       sr_ff       [0:RAD_BITS];
   eos_carry_type            c4_in;

   always_comb begin
      c4_in       = '0;
      c4_in.p_neg = s3_neg_ff;
      c4_in.vel   = s3_vel_ff;
      c4_in.npos  = s3_npos_ff;
      c4_in.sat   = s3_sat_ff;
      c4_in.r2    = s3_r2_ff;
      c4_in.zero  = (s3_r2_ff == '0);
      for (int i = 0; i < 3; i++) begin
         c4_in.num[i] = (NUM_BITS'(s3_nhi_ff[i]) << (WORD_BITS + FRAC_BITS))
                      + (NUM_BITS'(s3_nlo_ff[i]) << FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (en) begin
         sq_valid_ff[0] <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cr_ff[0] <= c4_in;
         sr_ff[0] <= s3_r2_ff;
      end
   end

   for (genvar j = 0; j < RAD_BITS; j++) begin : g_sqrt
      localparam int K = RAD_BITS - 1 - j;
      logic [TRIAL_BITS-1:0] trial;
      logic                  take;
      eos_carry_type         cr_in;
      logic [SQ_BITS-1:0]    sr_in;

      assign trial = (TRIAL_BITS'(cr_ff[j].root) << (K + 1)) + (TRIAL_BITS'(1) << (2 * K));
      assign take  = (TRIAL_BITS'(sr_ff[j]) >= trial);

      always_comb begin
         cr_in = cr_ff[j];
         sr_in = sr_ff[j];
         if (take) begin
            cr_in.root = cr_ff[j].root | (RAD_BITS'(1) << K);
            sr_in      = sr_ff[j] - trial[SQ_BITS-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[j+1] <= sq_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cr_ff[j+1] <= cr_in;
            sr_ff[j+1] <= sr_in;
         end
      end
   end

   // denominator r^2 * r in two halves
   logic                 m1_valid_ff, m2_valid_ff;
   eos_carry_type        m1_c_ff, m2_c_ff;
   eos_carry_type        m2_c_in;
   logic [SQ_BITS-1:0]   m1_lo_ff, m1_hi_ff;

   always_comb begin
      m2_c_in     = m1_c_ff;
      m2_c_in.den = (DEN_BITS'(m1_hi_ff) << RAD_BITS) + DEN_BITS'(m1_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= sq_valid_ff[RAD_BITS];
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_c_ff  <= cr_ff[RAD_BITS];
         m1_lo_ff <= SQ_BITS'(cr_ff[RAD_BITS].r2[RAD_BITS-1:0]) * SQ_BITS'(cr_ff[RAD_BITS].root);
         m1_hi_ff <= SQ_BITS'(cr_ff[RAD_BITS].r2[SQ_BITS-1:RAD_BITS])
                   * SQ_BITS'(cr_ff[RAD_BITS].root);
         m2_c_ff  <= m2_c_in;
      end
   end

   // overflow check, then one quotient bit per stage
   logic          dv_valid_ff [0:QUO_BITS];
   eos_carry_type dc_ff       [0:QUO_BITS];
   eos_div_type   dr_ff       [0:QUO_BITS];
   eos_div_type   d0_in;

   always_comb begin
      d0_in = '0;
      for (int i = 0; i < 3; i++) begin
         d0_in.rem[i] = m2_c_ff.num[i];
         d0_in.ovf[i] = CMP_BITS'(m2_c_ff.num[i]) >= (CMP_BITS'(m2_c_ff.den) << QUO_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dc_ff[0] <= m2_c_ff;
         dr_ff[0] <= d0_in;
      end
   end

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
      localparam int K = QUO_BITS - 1 - j;
      logic [CMP_BITS-1:0] shifted;
      eos_div_type         next;

      assign shifted = CMP_BITS'(dc_ff[j].den) << K;

      always_comb begin
         next = dr_ff[j];
         for (int i = 0; i < 3; i++) begin
            if (CMP_BITS'(dr_ff[j].rem[i]) >= shifted) begin
               next.rem[i] = dr_ff[j].rem[i] - shifted[NUM_BITS-1:0];
               next.quo[i] = dr_ff[j].quo[i] | (QUO_BITS'(1) << K);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dc_ff[j+1] <= dc_ff[j];
            dr_ff[j+1] <= next;
         end
      end
   end

   // final velocity update and result word
   logic          out_valid_ff;
   eos_rsp_type   out_word_ff;
   eos_rsp_type   out_word_in;

   always_comb begin
      eos_carry_type       c;
      eos_div_type         d;
      logic [QUO_BITS-1:0] dv;
      logic [EXT_BITS-1:0] vext, sum;
      logic [WORD_BITS:0]  cl;
      vec3_type            nvel;
      logic                sat;
      c   = dc_ff[QUO_BITS];
      d   = dr_ff[QUO_BITS];
      sat = c.sat;
      for (int i = 0; i < 3; i++) begin
         dv   = (d.ovf[i] || d.quo[i] > CAP) ? CAP : d.quo[i];
         vext = {{(EXT_BITS-WORD_BITS){c.vel[i][WORD_BITS-1]}}, c.vel[i]};
         sum  = c.p_neg[i] ? vext + EXT_BITS'(dv) : vext - EXT_BITS'(dv);
         cl   = clamp_ext(sum);
         if (c.zero) begin
            nvel[i] = c.vel[i];
         end else begin
            nvel[i] = cl[WORD_BITS-1:0];
            sat     = sat | cl[WORD_BITS];
         end
      end
      out_word_in.next_pos_x  = c.npos[0];
      out_word_in.next_pos_y  = c.npos[1];
      out_word_in.next_pos_z  = c.npos[2];
      out_word_in.next_vel_x  = nvel[0];
      out_word_in.next_vel_y  = nvel[1];
      out_word_in.next_vel_z  = nvel[2];
      out_word_in.radius      = c.root;
      out_word_in.saturated   = sat;
      out_word_in.zero_radius = c.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid_ff[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_word_ff <= out_word_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

`default_nettype wire

// ===== rtl/core/euler_orbit_step_core.sv =====
// ----------------------------------------------------------------------------
// euler_orbit_step_core
// One explicit Euler step of a body around a central mass, Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Takes one body state word (position and velocity) per cycle while req_stall
// is low and returns the state one step h later, with the old radius and the
// saturation and zero-radius flags. Throughput is one word per clock while
// req_stall is low; the pipeline depth is set by the square root (one root bit
// per stage) and the divider (one quotient bit per stage). A skid register at
// the output holds a word stalled by the receiver. The user must write
// step_size and gravity_parameter through the csr port only while no word is in
// flight; the block itself does not enforce this. Their product is registered.
`default_nettype none

module euler_orbit_step_core import eos_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire eos_req_type               req_word,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output eos_rsp_type                    rsp_word,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [STEP_BITS-1:0] step_ff;
   logic [GM_BITS-1:0]   gm_ff;
   logic [HGM_BITS-1:0]  hgm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         gm_ff   <= GM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEP_SIZE: step_ff <= csr_data[STEP_BITS-1:0];
            CSR_GRAVITY:   gm_ff   <= csr_data[GM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      hgm_ff <= HGM_BITS'(step_ff) * HGM_BITS'(gm_ff);
   end

   logic        skid_valid_ff;
   eos_rsp_type skid_ff;
   logic        pipe_en;
   logic        pipe_valid;
   eos_rsp_type pipe_word;

   // pipe freezes only while the skid register holds a word
   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   eos_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .step      (step_ff),
      .hgm       (hgm_ff),
      .out_valid (pipe_valid),
      .out_word  (pipe_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) skid_valid_ff <= 1'b0;
      end else if (pipe_valid && rsp_stall) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_ff <= pipe_word;
      end
   end

   assign rsp_valid = skid_valid_ff | pipe_valid;
   assign rsp_word  = skid_valid_ff ? skid_ff : pipe_word;

endmodule

`default_nettype wire
